[sv/sdst_pkg.sv]
// ----------------------------------------------------------------------------
// sdst_pkg: shared types and constants of the scanline dirty span tracker
// Table sizes, codes, the row cell command and the row record.
// ----------------------------------------------------------------------------
package sdst_pkg;

    localparam int MAX_ROWS   = 16;
    localparam int MAX_SPANS  = 8;
    localparam int COORD_BITS = 12;
    localparam int ROW_CNT_W  = 5;
    localparam int SPAN_CNT_W = 4;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ACT_PIXEL = 2'd0,
        ACT_SPAN  = 2'd1,
        ACT_READ  = 2'd2,
        ACT_CLEAR = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_ROW,
        OP_SPAN,
        OP_ABSORB
    } cell_op_t;

    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_CLIP_LEFT    = 3'd2;
    localparam logic [2:0] REG_CLIP_TOP     = 3'd3;
    localparam logic [2:0] REG_CLIP_RIGHT   = 3'd4;
    localparam logic [2:0] REG_CLIP_BOTTOM  = 3'd5;
    localparam logic [2:0] REG_TILED_MODE   = 3'd6;

    typedef struct packed {
        cell_op_t op;
        coord_t   y;
        coord_t   a;
        coord_t   b;
    } cell_cmd_t;

    typedef struct packed {
        logic                       valid;
        coord_t                     coord;
        logic [SPAN_CNT_W-1:0]      cnt;
        coord_t [MAX_SPANS-1:0]     sb;
        coord_t [MAX_SPANS-1:0]     sf;
    } row_t;

    typedef struct packed {
        logic full;
        logic absorbed;
    } cell_resp_t;

endpackage

[sv/sdst_wrap_unit.sv]
// ----------------------------------------------------------------------------
// sdst_wrap_unit: iterative signed wrap modulo the image size
// Restoring remainder, one quotient bit per cycle, floor-style for negatives.
// ----------------------------------------------------------------------------
module sdst_wrap_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [15:0]   value,
    input  logic [12:0]          modulus,
    output logic                 done,
    output sdst_pkg::coord_t     result
);
    import sdst_pkg::*;

    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [3:0]  step_reg, step_next;
    logic        neg_reg, neg_next;
    logic [14:0] u_reg, u_next;
    coord_t      rem_reg, rem_next;
    logic [12:0] mod_reg, mod_next;
    coord_t      result_reg, result_next;
    logic [12:0] trial;
    logic [12:0] rem_new;

    always_comb
    begin
        trial       = {rem_reg, u_reg[14]};
        rem_new     = (trial >= mod_reg) ? trial - mod_reg : trial;
        run_next    = run_reg;
        done_next   = 1'b0;
        step_next   = step_reg;
        neg_next    = neg_reg;
        u_next      = u_reg;
        rem_next    = rem_reg;
        mod_next    = mod_reg;
        result_next = result_reg;
        if (start)
        begin
            // negative v: wrap(v) = n - 1 - (~v mod n)
            run_next  = 1'b1;
            step_next = 4'd14;
            neg_next  = value[15];
            u_next    = value[15] ? ~value[14:0] : value[14:0];
            rem_next  = '0;
            mod_next  = modulus;
        end
        else if (run_reg)
        begin
            rem_next  = rem_new[COORD_BITS-1:0];
            u_next    = {u_reg[13:0], 1'b0};
            step_next = step_reg - 4'd1;
            if (step_reg == 4'd0)
            begin
                run_next    = 1'b0;
                done_next   = 1'b1;
                result_next = neg_reg ? COORD_BITS'(mod_reg - 13'd1 - rem_new)
                                      : rem_new[COORD_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg    <= neg_next;
        u_reg      <= u_next;
        rem_reg    <= rem_next;
        mod_reg    <= mod_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[sv/sdst_row_cell.sv]
// ----------------------------------------------------------------------------
// sdst_row_cell: one row of the sorted row chain
// Holds a row coordinate and its sorted span lanes; shifts from its left
// neighbor on row insert, merges, inserts and absorbs spans on command.
// ----------------------------------------------------------------------------
module sdst_row_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sdst_pkg::cell_cmd_t    cmd,
    input  sdst_pkg::row_t         left_row,
    input  logic                   left_lt,
    output sdst_pkg::row_t         row,
    output logic                   lt,
    output logic                   eq,
    output sdst_pkg::cell_resp_t   resp
);
    import sdst_pkg::*;

    logic                    valid_reg, valid_next;
    logic [SPAN_CNT_W-1:0]   cnt_reg, cnt_next;
    coord_t                  coord_reg, coord_next;
    coord_t [MAX_SPANS-1:0]  sb_reg, sb_next, sf_reg, sf_next;
    logic [MAX_SPANS-1:0]    lane_v, slt, head;
    logic                    touch, can_absorb, is_full;
    logic [COORD_BITS:0]     b_inc;

    assign lt = valid_reg && (coord_reg < cmd.y);
    assign eq = valid_reg && (coord_reg == cmd.y);

    always_comb
    begin
        b_inc      = {1'b0, cmd.b} + 1'b1;
        touch      = 1'b0;
        can_absorb = 1'b0;
        for (int k = 0; k < MAX_SPANS; k++)
        begin
            lane_v[k] = k < int'(cnt_reg);
            // lane lies wholly left of the new span, gap of at least one column
            slt[k]    = lane_v[k] && (({1'b0, sf_reg[k]} + 1'b1) < {1'b0, cmd.a});
        end
        head[0] = !slt[0];
        for (int k = 1; k < MAX_SPANS; k++)
            head[k] = !slt[k] && slt[k-1];
        for (int k = 0; k < MAX_SPANS; k++)
            if (head[k] && lane_v[k] && ({1'b0, sb_reg[k]} <= b_inc))
                touch = 1'b1;
        for (int k = 0; k < MAX_SPANS - 1; k++)
            if (head[k] && lane_v[k+1] &&
                ({1'b0, sb_reg[k+1]} <= ({1'b0, sf_reg[k]} + 1'b1)))
                can_absorb = 1'b1;
        is_full = cnt_reg == SPAN_CNT_W'(MAX_SPANS);
    end

    always_comb
    begin
        valid_next = valid_reg;
        cnt_next   = cnt_reg;
        coord_next = coord_reg;
        sb_next    = sb_reg;
        sf_next    = sf_reg;
        case (cmd.op)
            OP_CLEAR:
            begin
                valid_next = 1'b0;
                cnt_next   = '0;
            end
            OP_ROW:
            begin
                if (!lt)
                begin
                    if (left_lt)
                    begin
                        valid_next = 1'b1;
                        coord_next = cmd.y;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        valid_next = left_row.valid;
                        coord_next = left_row.coord;
                        cnt_next   = left_row.cnt;
                        sb_next    = left_row.sb;
                        sf_next    = left_row.sf;
                    end
                end
            end
            OP_SPAN:
            begin
                if (eq)
                begin
                    if (touch)
                    begin
                        for (int k = 0; k < MAX_SPANS; k++)
                            if (head[k])
                            begin
                                sb_next[k] = (sb_reg[k] > cmd.a) ? cmd.a : sb_reg[k];
                                sf_next[k] = (sf_reg[k] > cmd.b) ? sf_reg[k] : cmd.b;
                            end
                    end
                    else if (!is_full)
                    begin
                        if (head[0])
                        begin
                            sb_next[0] = cmd.a;
                            sf_next[0] = cmd.b;
                        end
                        for (int k = 1; k < MAX_SPANS; k++)
                            if (head[k])
                            begin
                                sb_next[k] = cmd.a;
                                sf_next[k] = cmd.b;
                            end
                            else if (!slt[k])
                            begin
                                sb_next[k] = sb_reg[k-1];
                                sf_next[k] = sf_reg[k-1];
                            end
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            OP_ABSORB:
            begin
                if (eq && can_absorb)
                begin
                    for (int k = 0; k < MAX_SPANS - 1; k++)
                        if (head[k])
                            sf_next[k] = (sf_reg[k+1] > sf_reg[k]) ? sf_reg[k+1] : sf_reg[k];
                        else if (!slt[k])
                        begin
                            sb_next[k] = sb_reg[k+1];
                            sf_next[k] = sf_reg[k+1];
                        end
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign resp.full     = (cmd.op == OP_SPAN) && eq && !touch && is_full;
    assign resp.absorbed = (cmd.op == OP_ABSORB) && eq && can_absorb;

    assign row.valid = valid_reg;
    assign row.coord = coord_reg;
    assign row.cnt   = cnt_reg;
    assign row.sb    = sb_reg;
    assign row.sf    = sf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        coord_reg <= coord_next;
        sb_reg    <= sb_next;
        sf_reg    <= sf_next;
    end

endmodule

[sv/scanline_dirty_span_tracker.sv]
// ----------------------------------------------------------------------------
// scanline_dirty_span_tracker: dirty row and span table
// Sorted chain of row cells with per-row span lanes, a wrap unit for tiled
// coordinates, an APB register file and the command sequencer.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low; its result is
// shown for exactly one cycle with done high and cannot be held off, so
// capture it on that cycle. Read and clear show their result on the cycle
// after the beat. A clipped mark runs a row step, a span step and absorb
// steps until no neighbor span is absorbed, then shows the result; a tiled
// mark first wraps y and then x in the shared remainder unit, and a piece
// that crosses the right edge runs the row/span/absorb steps a second time.
module scanline_dirty_span_tracker (
    input  logic                 clk,
    input  logic                 rst_n,
    // command channel
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           action,
    input  logic signed [15:0]   x_first,
    input  logic signed [15:0]   x_last,
    input  logic signed [15:0]   y_row,
    input  logic [3:0]           row_slot,
    input  logic [2:0]           span_slot,
    // result channel
    output logic                 done,
    output logic [1:0]           status,
    output logic                 entry_valid,
    output logic [11:0]          read_row_y,
    output logic [11:0]          read_span_start,
    output logic [11:0]          read_span_end,
    output logic [4:0]           rows_in_use,
    output logic [3:0]           spans_in_row,
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import sdst_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRAP_Y,
        S_WRAP_X,
        S_ROW,
        S_SPAN,
        S_ABSORB
    } state_t;

    localparam logic [12:0] FULL_SIZE = 13'(1 << COORD_BITS);

    // ---------------- configuration registers ----------------
    logic [12:0] width_reg, height_reg;
    coord_t      clip_left_reg, clip_top_reg, clip_right_reg, clip_bottom_reg;
    logic        tiled_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg       <= FULL_SIZE;
            height_reg      <= FULL_SIZE;
            clip_left_reg   <= '0;
            clip_top_reg    <= '0;
            clip_right_reg  <= '1;
            clip_bottom_reg <= '1;
            tiled_reg       <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_IMAGE_WIDTH:  width_reg       <= pwdata[12:0];
                REG_IMAGE_HEIGHT: height_reg      <= pwdata[12:0];
                REG_CLIP_LEFT:    clip_left_reg   <= pwdata[11:0];
                REG_CLIP_TOP:     clip_top_reg    <= pwdata[11:0];
                REG_CLIP_RIGHT:   clip_right_reg  <= pwdata[11:0];
                REG_CLIP_BOTTOM:  clip_bottom_reg <= pwdata[11:0];
                REG_TILED_MODE:   tiled_reg       <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_IMAGE_WIDTH:  prdata = {19'd0, width_reg};
            REG_IMAGE_HEIGHT: prdata = {19'd0, height_reg};
            REG_CLIP_LEFT:    prdata = {20'd0, clip_left_reg};
            REG_CLIP_TOP:     prdata = {20'd0, clip_top_reg};
            REG_CLIP_RIGHT:   prdata = {20'd0, clip_right_reg};
            REG_CLIP_BOTTOM:  prdata = {20'd0, clip_bottom_reg};
            REG_TILED_MODE:   prdata = {31'd0, tiled_reg};
            default:          prdata = '0;
        endcase
    end

    // Effective image size: 0 acts as 1, above the coordinate range saturates.
    logic [12:0] w_eff, h_eff;
    assign w_eff = (width_reg == '0) ? 13'd1 : (width_reg > FULL_SIZE) ? FULL_SIZE : width_reg;
    assign h_eff = (height_reg == '0) ? 13'd1 : (height_reg > FULL_SIZE) ? FULL_SIZE : height_reg;

    // ---------------- row cell chain ----------------
    cell_cmd_t              cmd;
    row_t                   rows [MAX_ROWS];
    logic [MAX_ROWS-1:0]    lt_vec, eq_vec, valid_vec;
    cell_resp_t             resp_vec [MAX_ROWS];
    cell_resp_t             resp_any;
    logic                   row_hit;

    for (genvar g = 0; g < MAX_ROWS; g++)
    begin : g_cell
        row_t left_row;
        logic left_lt;
        if (g == 0)
        begin : g_first
            assign left_row = '0;
            assign left_lt  = 1'b1;     // head of chain: nothing to its left
        end
        else
        begin : g_rest
            assign left_row = rows[g-1];
            assign left_lt  = lt_vec[g-1];
        end
        sdst_row_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .left_row (left_row),
            .left_lt  (left_lt),
            .row      (rows[g]),
            .lt       (lt_vec[g]),
            .eq       (eq_vec[g]),
            .resp     (resp_vec[g])
        );
        assign valid_vec[g] = rows[g].valid;
    end

    always_comb
    begin
        resp_any = '0;
        for (int k = 0; k < MAX_ROWS; k++)
            resp_any = resp_any | resp_vec[k];
    end
    assign row_hit = |eq_vec;

    // ---------------- wrap unit ----------------
    logic               wrap_start, wrap_done;
    logic signed [15:0] wrap_val;
    logic [12:0]        wrap_mod;
    coord_t             wrap_res;

    sdst_wrap_unit u_wrap (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (wrap_start),
        .value   (wrap_val),
        .modulus (wrap_mod),
        .done    (wrap_done),
        .result  (wrap_res)
    );

    // ---------------- sequencer ----------------
    state_t                state_reg, state_next;
    logic [ROW_CNT_W-1:0]  row_count_reg, row_count_next;
    logic                  done_reg, done_next;
    logic [1:0]            status_reg, status_next;
    logic                  ev_reg, ev_next;
    coord_t                ry_reg, ry_next, rsb_reg, rsb_next, rsf_reg, rsf_next;
    logic [3:0]            sir_reg, sir_next;

    coord_t                y_reg, y_next, a_reg, a_next, b_reg, b_next;
    coord_t                b2_reg, b2_next;
    logic                  two_reg, two_next;
    logic [1:0]            stat_reg, stat_next;
    logic signed [15:0]    x1_reg, x1_next;
    logic [16:0]           len_reg, len_next;

    logic signed [16:0]    x1s, x2s, ys, lo17, hi17;
    logic signed [17:0]    len18;
    logic [12:0]           end13;
    logic                  piece_end;
    logic [1:0]            piece_stat;
    row_t                  rd_row;
    logic                  accept;

    assign accept = start && (state_reg == S_IDLE);
    assign rd_row = rows[row_slot];

    always_comb
    begin
        state_next     = state_reg;
        row_count_next = row_count_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        ev_next        = ev_reg;
        ry_next        = ry_reg;
        rsb_next       = rsb_reg;
        rsf_next       = rsf_reg;
        sir_next       = sir_reg;
        y_next         = y_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        b2_next        = b2_reg;
        two_next       = two_reg;
        stat_next      = stat_reg;
        x1_next        = x1_reg;
        len_next       = len_reg;
        cmd.op         = OP_NONE;
        cmd.y          = y_reg;
        cmd.a          = a_reg;
        cmd.b          = b_reg;
        wrap_start     = 1'b0;
        wrap_val       = y_row;
        wrap_mod       = h_eff;
        piece_end      = 1'b0;
        piece_stat     = ST_OK;

        x1s   = 17'(x_first);
        x2s   = (action == ACT_PIXEL) ? 17'(x_first) : 17'(x_last);
        ys    = 17'(y_row);
        lo17  = (x1s < $signed({5'd0, clip_left_reg})) ? $signed({5'd0, clip_left_reg}) : x1s;
        hi17  = (x2s > $signed({5'd0, clip_right_reg})) ? $signed({5'd0, clip_right_reg}) : x2s;
        len18 = 18'(x2s) - 18'(x1s) + 18'sd1;
        end13 = {1'b0, wrap_res} + len_reg[12:0] - 13'd1;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ev_next   = 1'b0;
                    ry_next   = '0;
                    rsb_next  = '0;
                    rsf_next  = '0;
                    sir_next  = '0;
                    stat_next = ST_OK;
                    two_next  = 1'b0;
                    case (action)
                        ACT_CLEAR:
                        begin
                            cmd.op         = OP_CLEAR;
                            row_count_next = '0;
                            status_next    = ST_OK;
                            done_next      = 1'b1;
                        end
                        ACT_READ:
                        begin
                            status_next = ST_EMPTY;
                            done_next   = 1'b1;
                            if (rd_row.valid)
                            begin
                                ry_next  = rd_row.coord;
                                sir_next = rd_row.cnt;
                                if ({1'b0, span_slot} < rd_row.cnt)
                                begin
                                    ev_next     = 1'b1;
                                    status_next = ST_OK;
                                    rsb_next    = rd_row.sb[span_slot];
                                    rsf_next    = rd_row.sf[span_slot];
                                end
                            end
                        end
                        default:
                        begin
                            if (tiled_reg)
                            begin
                                if (x1s > x2s)
                                begin
                                    status_next = ST_EMPTY;
                                    done_next   = 1'b1;
                                end
                                else
                                begin
                                    x1_next    = x_first;
                                    len_next   = len18[16:0];
                                    wrap_start = 1'b1;
                                    state_next = S_WRAP_Y;
                                end
                            end
                            else if (ys < $signed({5'd0, clip_top_reg}) ||
                                     ys > $signed({5'd0, clip_bottom_reg}) || lo17 > hi17)
                            begin
                                status_next = ST_EMPTY;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                y_next     = y_row[COORD_BITS-1:0];
                                a_next     = lo17[COORD_BITS-1:0];
                                b_next     = hi17[COORD_BITS-1:0];
                                state_next = S_ROW;
                            end
                        end
                    endcase
                end
            end
            S_WRAP_Y:
            begin
                wrap_val = x1_reg;
                wrap_mod = w_eff;
                if (wrap_done)
                begin
                    y_next     = wrap_res;
                    wrap_start = 1'b1;
                    state_next = S_WRAP_X;
                end
            end
            S_WRAP_X:
            begin
                if (wrap_done)
                begin
                    state_next = S_ROW;
                    if ({4'd0, w_eff} <= len_reg)
                    begin
                        // as wide as the image: whole row
                        a_next = '0;
                        b_next = COORD_BITS'(w_eff - 13'd1);
                    end
                    else if (end13 <= w_eff - 13'd1)
                    begin
                        a_next = wrap_res;
                        b_next = end13[COORD_BITS-1:0];
                    end
                    else
                    begin
                        // crosses the right edge: right piece now, left piece after
                        a_next   = wrap_res;
                        b_next   = COORD_BITS'(w_eff - 13'd1);
                        b2_next  = COORD_BITS'(end13 - w_eff);
                        two_next = 1'b1;
                    end
                end
            end
            S_ROW:
            begin
                if (row_hit)
                    state_next = S_SPAN;
                else if (row_count_reg < ROW_CNT_W'(MAX_ROWS))
                begin
                    cmd.op         = OP_ROW;
                    row_count_next = row_count_reg + 1'b1;
                    state_next     = S_SPAN;
                end
                else
                begin
                    piece_end  = 1'b1;
                    piece_stat = ST_FULL;
                end
            end
            S_SPAN:
            begin
                cmd.op = OP_SPAN;
                if (resp_any.full)
                begin
                    piece_end  = 1'b1;
                    piece_stat = ST_FULL;
                end
                else
                    state_next = S_ABSORB;
            end
            S_ABSORB:
            begin
                cmd.op = OP_ABSORB;
                if (!resp_any.absorbed)
                    piece_end = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (piece_end)
        begin
            // worse status wins; marks only yield ok or full
            if (two_reg)
            begin
                stat_next  = stat_reg | piece_stat;
                a_next     = '0;
                b_next     = b2_reg;
                two_next   = 1'b0;
                state_next = S_ROW;
            end
            else
            begin
                status_next = stat_reg | piece_stat;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_count_reg <= '0;
            done_reg      <= 1'b0;
            two_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_count_reg <= row_count_next;
            done_reg      <= done_next;
            two_reg       <= two_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        ev_reg     <= ev_next;
        ry_reg     <= ry_next;
        rsb_reg    <= rsb_next;
        rsf_reg    <= rsf_next;
        sir_reg    <= sir_next;
        y_reg      <= y_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        b2_reg     <= b2_next;
        stat_reg   <= stat_next;
        x1_reg     <= x1_next;
        len_reg    <= len_next;
    end

    assign busy            = state_reg != S_IDLE;
    assign done            = done_reg;
    assign status          = status_reg;
    assign entry_valid     = ev_reg;
    assign read_row_y      = ry_reg;
    assign read_span_start = rsb_reg;
    assign read_span_end   = rsf_reg;
    assign rows_in_use     = row_count_reg;
    assign spans_in_row    = sir_reg;

    // ---------------- checks ----------------
    a_row_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        row_count_reg <= ROW_CNT_W'(MAX_ROWS))
        else $error("row count above table size");

    a_valid_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(row_count_reg))
        else $error("valid rows disagree with row count");

    a_unique_row: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(eq_vec))
        else $error("row coordinate held by more than one cell");

    a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && entry_valid |-> status == ST_OK)
        else $error("valid entry reported with bad status");

endmodule
